/* rtl/core/ktaf_pkg.sv */
// ----------------------------------------------------------------------------
// ktaf_pkg
// Types, constants and helper functions of the two-state Kalman tilt filter.
// ----------------------------------------------------------------------------
package ktaf_pkg;

    localparam int Frac  = 24;
    localparam int AddrW = 4;

    localparam logic [AddrW-1:0] RegQAngle = 4'h0;
    localparam logic [AddrW-1:0] RegQGyro  = 4'h4;
    localparam logic [AddrW-1:0] RegRAngle = 4'h8;
    localparam logic [AddrW-1:0] RegPeriod = 4'hC;

    localparam logic [30:0] QAngleRst = 31'd16777;
    localparam logic [30:0] QGyroRst  = 31'd50332;
    localparam logic [30:0] RAngleRst = 31'd8388608;
    localparam logic [23:0] PeriodRst = 24'd167772;
    localparam logic signed [31:0] OneQ24 = 32'sd16777216;

    typedef struct packed {
        logic signed [31:0] accel_angle_x;
        logic signed [31:0] accel_angle_y;
        logic signed [31:0] gyro_rate_x;
        logic signed [31:0] gyro_rate_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] bias_x;
        logic signed [31:0] bias_y;
    } out_beat_t;

    typedef struct packed {
        logic [30:0] q_angle;
        logic [30:0] q_gyro;
        logic [30:0] r_angle;
        logic [23:0] period;
    } cfg_t;

    // Microcode steps of one axis.
    typedef enum logic [4:0] {
        OP_PRED_ANG,   // angle + rnd((rate-bias)*dt)
        OP_PRED_P00,   // p00 + rnd((-p01-p10)*dt) + q
        OP_PRED_P01,   // t = rnd(p11*dt), p01 -= t, p10 -= t
        OP_PRED_P11,   // p11 += q_gyro, err, E
        OP_DIV0,       // start k0 division
        OP_DIV1,       // start k1 division
        OP_UPD_P00,
        OP_UPD_P01,
        OP_UPD_P10,
        OP_UPD_P11,
        OP_UPD_ANG,
        OP_UPD_BIAS,
        OP_SKIP,       // no correction path
        OP_LOAD,       // load axis state into work regs
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
        logic store;
        logic out_load;
        logic in_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic e_pos;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // floor((x + 2^23) / 2^24)
    function automatic logic signed [65:0] rnd24(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = x + 66'sd8388608;
        return y >>> Frac;
    endfunction

endpackage

/* rtl/core/ktaf_div.sv */
// ----------------------------------------------------------------------------
// ktaf_div
// Radix-2 restoring divider: quotient of (p * 2^24) / e, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ktaf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] p,
    input  logic        [32:0] e,
    output logic               busy,
    output logic signed [31:0] q
);
    import ktaf_pkg::*;

    localparam int NumW = 56;

    logic [NumW-1:0] num_reg, num_next;
    logic [NumW-1:0] quo_reg, quo_next;
    logic [33:0]     rem_reg, rem_next;
    logic [32:0]     den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [33:0]     trial;
    logic [31:0]     pmag;
    logic signed [65:0] sq;

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        pmag      = p[31] ? 32'(-p) : 32'(p);
        trial     = {rem_reg[32:0], num_reg[NumW-1]} - {1'b0, den_reg};
        if (start) begin
            num_next  = {pmag, 24'd0};
            quo_next  = '0;
            rem_next  = '0;
            den_next  = e;
            neg_next  = p[31];
            cnt_next  = 6'(NumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NumW-2:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial;
                quo_next = {quo_reg[NumW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[32:0], num_reg[NumW-1]};
                quo_next = {quo_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    assign sq   = neg_reg ? -$signed({10'd0, quo_reg}) : $signed({10'd0, quo_reg});
    assign q    = sat32(sq);
    assign busy = busy_reg;

endmodule

/* rtl/core/ktaf_datapath.sv */
// ----------------------------------------------------------------------------
// ktaf_datapath
// Axis state, working registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module ktaf_datapath #(
    parameter int NUM_AXES = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ktaf_pkg::cfg_t    cfg,
    input  ktaf_pkg::cmd_t    cmd,
    input  logic [(NUM_AXES > 1 ? $clog2(NUM_AXES) : 1)-1:0] axis,
    input  ktaf_pkg::in_beat_t in_beat,
    output ktaf_pkg::sts_t    sts,
    output ktaf_pkg::out_beat_t out_beat
);
    import ktaf_pkg::*;

    localparam int AxW = NUM_AXES > 1 ? $clog2(NUM_AXES) : 1;

    logic signed [31:0] ang_st_reg  [NUM_AXES];
    logic signed [31:0] bias_st_reg [NUM_AXES];
    logic signed [31:0] p00_st_reg  [NUM_AXES];
    logic signed [31:0] p01_st_reg  [NUM_AXES];
    logic signed [31:0] p10_st_reg  [NUM_AXES];
    logic signed [31:0] p11_st_reg  [NUM_AXES];

    in_beat_t           in_reg;
    out_beat_t          out_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] nang_reg, nbias_reg, n00_reg, n01_reg, n10_reg, n11_reg;
    logic signed [31:0] err_reg, k0_reg, k1_reg;
    logic        [32:0] e_reg;
    logic signed [31:0] accel, rate;

    logic signed [33:0] ma, mb;
    logic signed [67:0] prod_full;
    logic signed [65:0] prod;
    logic signed [31:0] div_p;
    logic               div_busy;
    logic signed [31:0] div_q;
    logic signed [33:0] e_full;

    always_comb begin
        accel = '0;
        rate  = '0;
        if (axis == AxW'(0)) begin
            accel = in_reg.accel_angle_x;
            rate  = in_reg.gyro_rate_x;
        end else if (axis == AxW'(1)) begin
            accel = in_reg.accel_angle_y;
            rate  = in_reg.gyro_rate_y;
        end
    end

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_PRED_ANG: begin
                ma = 34'(rate) - 34'(bias_reg);
                mb = $signed({10'd0, cfg.period});
            end
            OP_PRED_P00: begin
                ma = -34'(p01_reg) - 34'(p10_reg);
                mb = $signed({10'd0, cfg.period});
            end
            OP_PRED_P01: begin
                ma = 34'(p11_reg);
                mb = $signed({10'd0, cfg.period});
            end
            OP_UPD_P00: begin ma = 34'(k0_reg); mb = 34'(p00_reg); end
            OP_UPD_P01: begin ma = 34'(k0_reg); mb = 34'(p01_reg); end
            OP_UPD_P10: begin ma = 34'(k1_reg); mb = 34'(p00_reg); end
            OP_UPD_P11: begin ma = 34'(k1_reg); mb = 34'(p01_reg); end
            OP_UPD_ANG: begin ma = 34'(k0_reg); mb = 34'(err_reg); end
            OP_UPD_BIAS: begin ma = 34'(k1_reg); mb = 34'(err_reg); end
            default: ;
        endcase
    end

    assign prod_full = ma * mb;
    assign prod      = prod_full[65:0];
    assign e_full    = 34'($signed({3'd0, cfg.r_angle})) + 34'(p00_reg);
    assign div_p     = (cmd.op == OP_DIV1) ? p10_reg : p00_reg;

    ktaf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .p       (div_p),
        .e       (e_reg),
        .busy    (div_busy),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.in_load)
            in_reg <= in_beat;
        unique case (cmd.op)
            OP_LOAD: begin
                ang_reg  <= ang_st_reg[axis[AxW-1:0]];
                bias_reg <= bias_st_reg[axis[AxW-1:0]];
                p00_reg  <= p00_st_reg[axis[AxW-1:0]];
                p01_reg  <= p01_st_reg[axis[AxW-1:0]];
                p10_reg  <= p10_st_reg[axis[AxW-1:0]];
                p11_reg  <= p11_st_reg[axis[AxW-1:0]];
            end
            OP_PRED_ANG: ang_reg <= sat32(66'(ang_reg) + rnd24(prod));
            OP_PRED_P00:
                p00_reg <= sat32(66'(p00_reg) + rnd24(prod)
                                 + $signed({35'd0, cfg.q_angle}));
            OP_PRED_P01: begin
                p01_reg <= sat32(66'(p01_reg) - rnd24(prod));
                p10_reg <= sat32(66'(p10_reg) - rnd24(prod));
            end
            OP_PRED_P11: begin
                p11_reg <= sat32(66'(p11_reg) + $signed({35'd0, cfg.q_gyro}));
                err_reg <= sat32(66'(accel) - 66'(ang_reg));
                e_reg   <= e_full[32:0];
            end
            OP_DIV0: ;
            OP_DIV1: k0_reg <= div_q;
            OP_UPD_P00: begin
                k1_reg  <= div_q;
                n00_reg <= sat32(66'(p00_reg) - rnd24(prod));
            end
            OP_UPD_P01:  n01_reg   <= sat32(66'(p01_reg) - rnd24(prod));
            OP_UPD_P10:  n10_reg   <= sat32(66'(p10_reg) - rnd24(prod));
            OP_UPD_P11:  n11_reg   <= sat32(66'(p11_reg) - rnd24(prod));
            OP_UPD_ANG:  nang_reg  <= sat32(66'(ang_reg) - (-rnd24(prod)));
            OP_UPD_BIAS: nbias_reg <= sat32(66'(bias_reg) + rnd24(prod));
            OP_SKIP: begin
                n00_reg   <= p00_reg;
                n01_reg   <= p01_reg;
                n10_reg   <= p10_reg;
                n11_reg   <= p11_reg;
                nang_reg  <= ang_reg;
                nbias_reg <= bias_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (!aresetn) begin
                ang_st_reg[i]  <= '0;
                bias_st_reg[i] <= '0;
                p00_st_reg[i]  <= OneQ24;
                p01_st_reg[i]  <= '0;
                p10_st_reg[i]  <= '0;
                p11_st_reg[i]  <= OneQ24;
            end else if (cmd.store && axis == AxW'(i)) begin
                ang_st_reg[i]  <= nang_reg;
                bias_st_reg[i] <= nbias_reg;
                p00_st_reg[i]  <= n00_reg;
                p01_st_reg[i]  <= n01_reg;
                p10_st_reg[i]  <= n10_reg;
                p11_st_reg[i]  <= n11_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.angle_x <= ang_st_reg[0];
            out_reg.bias_x  <= bias_st_reg[0];
            if (NUM_AXES > 1) begin
                out_reg.angle_y <= ang_st_reg[NUM_AXES > 1 ? 1 : 0];
                out_reg.bias_y  <= bias_st_reg[NUM_AXES > 1 ? 1 : 0];
            end else begin
                out_reg.angle_y <= '0;
                out_reg.bias_y  <= '0;
            end
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.e_pos    = !e_reg[32] && (e_reg != '0);
    assign out_beat     = out_reg;

endmodule

/* rtl/core/ktaf_ctrl.sv */
// ----------------------------------------------------------------------------
// ktaf_ctrl
// Sequencer: predict per axis, then gain division and correction if E > 0.
// ----------------------------------------------------------------------------
module ktaf_ctrl #(
    parameter int NUM_AXES = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  ktaf_pkg::sts_t sts,
    output ktaf_pkg::cmd_t cmd,
    output logic [(NUM_AXES > 1 ? $clog2(NUM_AXES) : 1)-1:0] axis
);
    import ktaf_pkg::*;

    localparam int AxW = NUM_AXES > 1 ? $clog2(NUM_AXES) : 1;

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [AxW-1:0] axis_reg, axis_next;
    logic           mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
            axis_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        axis_next     = axis_reg;
        mv_next       = mv_reg;
        cmd           = '0;
        cmd.op        = OP_NONE;
        s_ready       = 1'b0;
        if (mv_reg && m_ready)
            mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    axis_next   = '0;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.op     = OP_LOAD;
                op_next    = OP_PRED_ANG;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.op = op_reg;
                unique case (op_reg)
                    OP_PRED_ANG: op_next = OP_PRED_P00;
                    OP_PRED_P00: op_next = OP_PRED_P01;
                    OP_PRED_P01: op_next = OP_PRED_P11;
                    OP_PRED_P11: op_next = OP_DIV0;
                    OP_DIV0: begin
                        if (sts.e_pos) begin
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                            op_next       = OP_DIV1;
                        end else begin
                            op_next = OP_SKIP;
                        end
                    end
                    OP_DIV1: begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                        op_next       = OP_UPD_P00;
                    end
                    OP_UPD_P00:  op_next = OP_UPD_P01;
                    OP_UPD_P01:  op_next = OP_UPD_P10;
                    OP_UPD_P10:  op_next = OP_UPD_P11;
                    OP_UPD_P11:  op_next = OP_UPD_ANG;
                    OP_UPD_ANG:  op_next = OP_UPD_BIAS;
                    OP_UPD_BIAS: state_next = ST_STORE;
                    OP_SKIP:     state_next = ST_STORE;
                    default:     state_next = ST_STORE;
                endcase
            end
            ST_DIV: begin
                if (!sts.div_busy)
                    state_next = ST_STEP;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (axis_reg == AxW'(NUM_AXES - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next  = axis_reg + AxW'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
    assign axis    = axis_reg;

endmodule

/* rtl/core/kalman_tilt_angle_filter.sv */
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter
// Two-state Kalman tilt filter (angle, gyro bias) per axis, fixed point.
//
//   channel   dir  handshake           payload
//   s_        in   s_valid/s_ready     in_beat_t
//   m_        out  m_valid/m_ready     out_beat_t
//   apb       in   psel/penable        four config registers
//
// Per axis, two 56-step gain divisions in the shared divider dominate the
// time of a beat when the innovation variance is positive.
// Reset clears state to zero angle/bias and unit covariance.
// The next input beat is taken while the previous result waits on m_ready.
// A finished beat holds in the output step until the previous result leaves.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter #(
    parameter int NUM_AXES = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ktaf_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ktaf_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ktaf_pkg::*;

    localparam int AxW = NUM_AXES > 1 ? $clog2(NUM_AXES) : 1;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic [AxW-1:0] axis;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.q_angle <= QAngleRst;
            cfg_reg.q_gyro  <= QGyroRst;
            cfg_reg.r_angle <= RAngleRst;
            cfg_reg.period  <= PeriodRst;
        end else if (wr) begin
            unique case (paddr)
                RegQAngle: cfg_reg.q_angle <= pwdata[30:0];
                RegQGyro:  cfg_reg.q_gyro  <= pwdata[30:0];
                RegRAngle: cfg_reg.r_angle <= pwdata[30:0];
                RegPeriod: cfg_reg.period  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            RegQAngle: prdata = {1'b0, cfg_reg.q_angle};
            RegQGyro:  prdata = {1'b0, cfg_reg.q_gyro};
            RegRAngle: prdata = {1'b0, cfg_reg.r_angle};
            RegPeriod: prdata = {8'd0, cfg_reg.period};
            default:   prdata = '0;
        endcase
    end

    ktaf_ctrl #(.NUM_AXES(NUM_AXES)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd),
        .axis    (axis)
    );

    ktaf_datapath #(.NUM_AXES(NUM_AXES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .axis     (axis),
        .in_beat  (s_data),
        .sts      (sts),
        .out_beat (m_data)
    );

`ifndef NO_ASSERTIONS
    a_store_not_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> !sts.div_busy)
        else $error("state stored while divider busy");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op != OP_NONE |-> !s_ready)
        else $error("input taken mid item");
`endif

endmodule

/* tb/kalman_tilt_angle_filter_chk.sv */
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter_chk
// Watches both stream channels of the tilt filter, predicts each result beat from
// the accepted input beats and the register writes, and compares field by
// field in order. Reports mismatches and counts failures for the top.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter_chk #(
    parameter int NUM_AXES = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  ktaf_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  ktaf_pkg::out_beat_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ktaf_pkg::*;

    logic [30:0] q_ang, q_gyr, r_ang;
    logic [23:0] dt_q24;
    longint ang_st [NUM_AXES];
    longint bias_st [NUM_AXES];
    longint p00_st [NUM_AXES];
    longint p01_st [NUM_AXES];
    longint p10_st [NUM_AXES];
    longint p11_st [NUM_AXES];
    out_beat_t tilt_expected [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round24(longint x);
        return (x + 64'sd8388608) >>> 24;
    endfunction

    task automatic filter_axis(int i, longint accel, longint rate);
        longint dt, p00, p01, p10, p11, a, err, e, k0, k1;
        dt = longint'(dt_q24);
        p00 = p00_st[i]; p01 = p01_st[i]; p10 = p10_st[i]; p11 = p11_st[i];
        a = clamp32(ang_st[i] + round24((rate - bias_st[i]) * dt));
        p00 = clamp32(p00 + round24((-p01 - p10) * dt) + longint'(q_ang));
        p01 = clamp32(p01 - round24(p11 * dt));
        p10 = clamp32(p10 - round24(p11 * dt));
        p11 = clamp32(p11 + longint'(q_gyr));
        err = clamp32(accel - a);
        e = longint'(r_ang) + p00;
        if (e > 0) begin
            k0 = clamp32((p00 * 64'sd16777216) / e);
            k1 = clamp32((p10 * 64'sd16777216) / e);
            p00_st[i] = clamp32(p00 - round24(k0 * p00));
            p01_st[i] = clamp32(p01 - round24(k0 * p01));
            p10_st[i] = clamp32(p10 - round24(k1 * p00));
            p11_st[i] = clamp32(p11 - round24(k1 * p01));
            ang_st[i] = clamp32(a + round24(k0 * err));
            bias_st[i] = clamp32(bias_st[i] + round24(k1 * err));
        end else begin
            p00_st[i] = p00; p01_st[i] = p01; p10_st[i] = p10; p11_st[i] = p11;
            ang_st[i] = a;
        end
    endtask

    function automatic logic signed [31:0] lo32(longint v);
        return v[31:0];
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        out_beat_t got;
        if (!aresetn) begin
            q_ang <= QAngleRst; q_gyr <= QGyroRst; r_ang <= RAngleRst; dt_q24 <= PeriodRst;
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_st[i] = 0; bias_st[i] = 0; p01_st[i] = 0; p10_st[i] = 0;
                p00_st[i] = 16777216; p11_st[i] = 16777216;
            end
            tilt_expected.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    RegQAngle: q_ang <= pwdata[30:0];
                    RegQGyro:  q_gyr <= pwdata[30:0];
                    RegRAngle: r_ang <= pwdata[30:0];
                    RegPeriod: dt_q24 <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (i == 0) filter_axis(0, s_data.accel_angle_x, s_data.gyro_rate_x);
                    else if (i == 1) filter_axis(1, s_data.accel_angle_y, s_data.gyro_rate_y);
                    else filter_axis(i, 0, 0);
                end
                want = '0;
                want.angle_x = lo32(ang_st[0]);
                want.bias_x = lo32(bias_st[0]);
                if (NUM_AXES > 1) begin
                    want.angle_y = lo32(ang_st[1]);
                    want.bias_y = lo32(bias_st[1]);
                end
                tilt_expected.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (tilt_expected.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = tilt_expected.pop_front();
                    if (got.angle_x !== want.angle_x || got.angle_y !== want.angle_y ||
                        got.bias_x !== want.bias_x || got.bias_y !== want.bias_y) begin
                        $display("%0t: mismatch expected ax %h ay %h bx %h by %h", $time,
                                 want.angle_x, want.angle_y, want.bias_x, want.bias_y);
                        $display("%0t:          actual   ax %h ay %h bx %h by %h", $time,
                                 got.angle_x, got.angle_y, got.bias_x, got.bias_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= tilt_expected.size();
        end
    end
endmodule

/* tb/kalman_tilt_angle_filter_tb.sv */
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter_tb
// Drives the tilt filter with directed and random sensor beats across several
// register settings and idling and stall phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ktaf_pkg::*;

    localparam longint CycleLimit = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 1'b0;
    longint cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    kalman_tilt_angle_filter u_top (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    kalman_tilt_angle_filter_chk u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic send_sample(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_field(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(2 * 65536 * 90) - 65536 * 90;
            2: return $urandom_range(65536 * 10) - 65536 * 5;
            default: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic in_beat_t rand_sample(bit wild);
        in_beat_t b;
        int k;
        k = wild ? $urandom_range(3) : (1 + $urandom_range(1));
        b.accel_angle_x = rand_field(k);
        b.accel_angle_y = rand_field(wild ? $urandom_range(3) : 1);
        b.gyro_rate_x = rand_field(wild ? $urandom_range(3) : 2);
        b.gyro_rate_y = rand_field(wild ? $urandom_range(3) : 2);
        return b;
    endfunction

    task automatic set_regs(logic [31:0] qa, logic [31:0] qg, logic [31:0] ra,
                            logic [31:0] dt);
        reg_write(RegQAngle, qa);
        reg_write(RegQGyro, qg);
        reg_write(RegRAngle, ra);
        reg_write(RegPeriod, dt);
    endtask

    initial begin
        in_beat_t b;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        b = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        send_sample(b);
        b = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send_sample(b);
        send_sample('0);
        send_sample('1);
        for (int i = 0; i < 6; i++) send_sample(rand_sample(1'b0));
        drain();
        set_regs(32'h0, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 5; i++) send_sample(rand_sample(1'b1));
        drain();
        set_regs(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffff);
        for (int i = 0; i < 6; i++) send_sample(rand_sample(1'b1));
        drain();
        set_regs(32'd16777, 32'd50332, 32'd8388608, 32'd167772);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (3000) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 200; i++) send_sample(rand_sample($urandom_range(9) == 0));
            drain();
            case (ph)
                0: set_regs($urandom() >> 8, $urandom() >> 10, 32'd1, $urandom_range(1, 4000));
                1: set_regs($urandom(), $urandom(), $urandom(), $urandom());
                2: set_regs(32'd1000, 32'd3000, 32'h1000000, 32'd16777);
                default: set_regs(32'd16777, 32'd50332, 32'd8388608, 32'd167772);
            endcase
        end

        drain();
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/ktaf_pkg.sv
rtl/core/ktaf_div.sv
rtl/core/ktaf_datapath.sv
rtl/core/ktaf_ctrl.sv
rtl/core/kalman_tilt_angle_filter.sv
tb/kalman_tilt_angle_filter_chk.sv
tb/kalman_tilt_angle_filter_tb.sv
